// ----- rtl/slcan_pkg.sv -----
// ----------------------------------------------------------------------------
// slcan_pkg
// Shared types, character codes and helpers for the CAN frame to SLCAN
// text encoder.
// ----------------------------------------------------------------------------
package slcan_pkg;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;
  localparam int unsigned MAX_LEN = 8;

  localparam logic [7:0] CH_STD_DATA = 8'h74;  // 't'
  localparam logic [7:0] CH_STD_RTR  = 8'h72;  // 'r'
  localparam logic [7:0] CH_EXT_DATA = 8'h54;  // 'T'
  localparam logic [7:0] CH_EXT_RTR  = 8'h52;  // 'R'
  localparam logic [7:0] CH_ZERO     = 8'h30;  // '0'
  localparam logic [7:0] CH_ALPHA    = 8'h57;  // 'a' minus ten
  localparam logic [7:0] CH_CR       = 8'h0d;

  localparam logic [2:0] STD_DIGITS_M1 = 3'd2;
  localparam logic [2:0] EXT_DIGITS_M1 = 3'd7;

  typedef struct packed {
    logic        is_extended;
    logic        is_remote;
    logic [28:0] can_id;
    logic [3:0]  data_length;
    logic [63:0] data_bytes;
  } frame_in_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } char_out_t;

  // Classified frame: identifier left-aligned for top-nibble-first output.
  typedef struct packed {
    logic [7:0]  letter;
    logic [31:0] id_sr;
    logic [2:0]  id_digits_m1;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? CH_ZERO : CH_ALPHA;
    return base + {4'b0000, nib};
  endfunction

endpackage

// ----- rtl/slcan_front.sv -----
// ----------------------------------------------------------------------------
// slcan_front
// Accepts frames, picks the type letter, masks the identifier, saturates
// the length and pushes the classified frame into the queue.
// ----------------------------------------------------------------------------
module slcan_front
  import slcan_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  frame_in_t   in_data,
  input  logic        q_full,
  output logic        q_push,
  output frame_desc_t q_desc
);

  logic [3:0] len_sat;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign len_sat  = (in_data.data_length > 4'(MAX_LEN)) ? 4'(MAX_LEN) : in_data.data_length;

  always_comb begin
    q_desc.len  = len_sat;
    q_desc.data = in_data.data_bytes;
    if (in_data.is_extended) begin
      q_desc.letter       = in_data.is_remote ? CH_EXT_RTR : CH_EXT_DATA;
      q_desc.id_sr        = {3'b000, in_data.can_id};
      q_desc.id_digits_m1 = EXT_DIGITS_M1;
    end else begin
      q_desc.letter       = in_data.is_remote ? CH_STD_RTR : CH_STD_DATA;
      q_desc.id_sr        = {1'b0, in_data.can_id[10:0], 20'h00000};
      q_desc.id_digits_m1 = STD_DIGITS_M1;
    end
  end

endmodule

// ----- rtl/slcan_queue.sv -----
// ----------------------------------------------------------------------------
// slcan_queue
// Two-entry queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module slcan_queue
  import slcan_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_desc_t push_desc,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output frame_desc_t q_desc
);

  frame_desc_t       entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_desc  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && q_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && q_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && q_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/slcan_back.sv -----
// ----------------------------------------------------------------------------
// slcan_back
// Serializes one classified frame into SLCAN text, one character per cycle
// while out_ready stays high, into a registered output stage.
// ----------------------------------------------------------------------------
module slcan_back
  import slcan_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  frame_desc_t q_desc,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output char_out_t   out_data
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LETTER = 6'b000010,
    ST_ID     = 6'b000100,
    ST_LEN    = 6'b001000,
    ST_DATA   = 6'b010000,
    ST_CR     = 6'b100000
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [7:0]  letter_r;
  logic [31:0] id_sr_r, id_sr_nxt;
  logic [3:0]  len_r;
  logic [63:0] data_r, data_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        hi_r, hi_nxt;
  logic        out_valid_r;
  char_out_t   out_data_r;
  logic        adv;
  logic        emit;
  logic        load;
  char_out_t   ch;

  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = adv && load;

  always_comb begin
    state_nxt     = state_r;
    id_sr_nxt     = id_sr_r;
    data_nxt      = data_r;
    cnt_nxt       = cnt_r;
    hi_nxt        = hi_r;
    emit          = 1'b1;
    load          = 1'b0;
    ch.ascii_char = CH_CR;
    ch.last       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        emit = 1'b0;
        load = q_valid;
      end
      ST_LETTER: begin
        ch.ascii_char = letter_r;
        state_nxt     = ST_ID;
      end
      ST_ID: begin
        ch.ascii_char = hex_char(id_sr_r[31:28]);
        id_sr_nxt     = {id_sr_r[27:0], 4'h0};
        if (cnt_r == '0) begin
          state_nxt = ST_LEN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_LEN: begin
        ch.ascii_char = CH_ZERO + {4'b0000, len_r};
        hi_nxt        = 1'b1;
        if (len_r == '0) begin
          state_nxt = ST_CR;
        end else begin
          cnt_nxt   = 3'(len_r - 4'd1);
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        ch.ascii_char = hex_char(hi_r ? data_r[7:4] : data_r[3:0]);
        if (hi_r) begin
          hi_nxt = 1'b0;
        end else begin
          hi_nxt   = 1'b1;
          data_nxt = {8'h00, data_r[63:8]};
          if (cnt_r == '0) begin
            state_nxt = ST_CR;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      ST_CR: begin
        ch.ascii_char = CH_CR;
        ch.last       = 1'b1;
        load          = q_valid;
        state_nxt     = ST_IDLE;
      end
      default: begin
        emit      = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      state_nxt = ST_LETTER;
      id_sr_nxt = q_desc.id_sr;
      cnt_nxt   = q_desc.id_digits_m1;
      data_nxt  = q_desc.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= ch;
      id_sr_r    <= id_sr_nxt;
      data_r     <= data_nxt;
      cnt_r      <= cnt_nxt;
      hi_r       <= hi_nxt;
      if (load) begin
        letter_r <= q_desc.letter;
        len_r    <= q_desc.len;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |-> (out_data_r.ascii_char == CH_CR))
    else $error("last flag on a character other than carriage return");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_letter_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_LETTER))
    else $error("frame load did not start with the type letter");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> (len_r <= 4'(MAX_LEN) && len_r != '0))
    else $error("data phase with bad length");
`endif

endmodule

// ----- rtl/can_frame_to_slcan_ascii.sv -----
// ----------------------------------------------------------------------------
// can_frame_to_slcan_ascii
// Encodes received CAN frames as SLCAN text, one ASCII character per item.
// ----------------------------------------------------------------------------
// Each frame becomes a type letter, 3 or 8 lower-case hex identifier digits,
// one length digit (lengths above 8 read as 8), two hex digits per data byte
// and a closing carriage return flagged by last: 6 to 27 characters. The
// character serializer emits one character per cycle while out_ready stays
// high; when it was idle, loading a frame emits nothing first, and frames
// waiting in the queue follow with no gap. A two-entry frame queue in front
// of it lets in_ready stay high while earlier frames are still being sent.
module can_frame_to_slcan_ascii
  import slcan_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  frame_in_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output char_out_t out_data
);

  logic        q_full;
  logic        q_push;
  frame_desc_t push_desc;
  logic        q_pop;
  logic        q_valid;
  frame_desc_t q_desc;

  slcan_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  slcan_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  slcan_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
